### rtl/hexrp_pkg.sv
// ----------------------------------------------------------------------------
// hexrp_pkg: shared definitions for the hex record parser
// Record geometry, character codes and result kinds.
// ----------------------------------------------------------------------------
package hexrp_pkg;

	localparam int DATA_BYTES = 16;
	localparam int HEAD_BYTES = 4;
	localparam int POS_W      = 7;
	localparam int IDX_W      = POS_W - 1;

	localparam logic [IDX_W-1:0] IDX_TYPE   = IDX_W'(HEAD_BYTES - 1);
	localparam logic [IDX_W-1:0] IDX_HEAD   = IDX_W'(HEAD_BYTES);
	localparam logic [IDX_W-1:0] IDX_BODY   = IDX_W'(HEAD_BYTES + DATA_BYTES);

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPA   = 8'h41;
	localparam logic [7:0] CHAR_UPZ   = 8'h5A;
	localparam logic [7:0] ALPHA_OFS  = 8'd55;
	localparam logic [7:0] DIGIT_OFS  = 8'd48;

	localparam logic [7:0] TYPE_DATA  = 8'h00;
	localparam logic [7:0] TYPE_EOF   = 8'h01;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_EOF  = 2'd3
	} kind_t;

	function automatic logic [7:0] decode_digit(input logic [7:0] c);
		logic [7:0] d;
		d = c;
		if (c >= CHAR_UPA && c <= CHAR_UPZ) begin
			d = c - ALPHA_OFS;
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = c - DIGIT_OFS;
		end
		return d;
	endfunction

endpackage

### rtl/hex_record_parser_checksum.sv
// ----------------------------------------------------------------------------
// hex_record_parser_checksum
// Intel HEX text parser: emits data bytes and per-record checksum status.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one ASCII character per word (s_tdata).
//   m_* channel gives one result word per data byte, per record checksum
//   and at end of file: m_tuser is the kind (data, good, bad, end of file),
//   m_tdata the data byte (zero for other kinds).
//   A character is registered at acceptance and decoded in the next cycle
//   against the parser state, which loads the result register while the
//   output can advance; m_tvalid shows the result register.
//   Throughput is one character per cycle while the receiver takes results;
//   the decode and state update between the two registers are combinational.
//   When the receiver stalls, the result holds; an empty input register still
//   takes one more character, and s_tready then drops until the result drains.
//   Reset clears the parser to outside any record with no pending words.
//   After an end-of-file record all further input is taken and dropped.
// ----------------------------------------------------------------------------
module hex_record_parser_checksum (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ascii_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] byte_value
	output logic [1:0] m_tuser    // [1:0] kind
);

	logic                        valid_s1;
	logic [7:0]                  char_s1;
	logic                        adv;

	logic [hexrp_pkg::POS_W-1:0] pos_q, pos_d;
	logic                        in_record_q, in_record_d;
	logic [3:0]                  high_digit_q, high_digit_d;
	logic [7:0]                  byte_sum_q, byte_sum_d;
	logic [7:0]                  record_type_q, record_type_d;
	logic                        finished_q, finished_d;

	logic                        out_valid_q;
	hexrp_pkg::kind_t            out_kind_q;
	logic [7:0]                  out_byte_q;

	logic                        emit;
	hexrp_pkg::kind_t            emit_kind;
	logic [7:0]                  emit_byte;
	logic [7:0]                  digit;
	logic [7:0]                  value;
	logic [hexrp_pkg::IDX_W-1:0] idx;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	assign digit = hexrp_pkg::decode_digit(char_s1);
	assign value = {high_digit_q, 4'd0} + digit;
	assign idx   = pos_q[hexrp_pkg::POS_W-1:1];

	always_comb begin
		pos_d         = pos_q;
		in_record_d   = in_record_q;
		high_digit_d  = high_digit_q;
		byte_sum_d    = byte_sum_q;
		record_type_d = record_type_q;
		finished_d    = finished_q;
		emit          = 1'b0;
		emit_kind     = hexrp_pkg::KIND_DATA;
		emit_byte     = 8'd0;
		if (valid_s1 && !finished_q) begin
			if (char_s1 == hexrp_pkg::CHAR_COLON) begin
				// restart, abandoning any open record
				in_record_d   = 1'b1;
				pos_d         = '0;
				high_digit_d  = 4'd0;
				byte_sum_d    = 8'd0;
				record_type_d = 8'd0;
			end else if (in_record_q) begin
				pos_d = pos_q + 1'b1;
				if (!pos_q[0]) begin
					high_digit_d = digit[3:0];
				end else if (idx < hexrp_pkg::IDX_BODY) begin
					byte_sum_d = byte_sum_q + value;
					if (idx == hexrp_pkg::IDX_TYPE) begin
						record_type_d = value;
						if (value == hexrp_pkg::TYPE_EOF) begin
							finished_d  = 1'b1;
							in_record_d = 1'b0;
							pos_d       = '0;
							emit        = 1'b1;
							emit_kind   = hexrp_pkg::KIND_EOF;
						end
					end else if (idx >= hexrp_pkg::IDX_HEAD &&
					             record_type_q == hexrp_pkg::TYPE_DATA) begin
						emit      = 1'b1;
						emit_kind = hexrp_pkg::KIND_DATA;
						emit_byte = value;
					end
				end else begin
					// checksum byte closes the record
					in_record_d = 1'b0;
					pos_d       = '0;
					emit        = 1'b1;
					emit_kind   = ((8'd0 - byte_sum_q) == value) ?
					              hexrp_pkg::KIND_GOOD : hexrp_pkg::KIND_BAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			in_record_q   <= 1'b0;
			high_digit_q  <= 4'd0;
			byte_sum_q    <= 8'd0;
			record_type_q <= 8'd0;
			finished_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else if (adv) begin
			pos_q         <= pos_d;
			in_record_q   <= in_record_d;
			high_digit_q  <= high_digit_d;
			byte_sum_q    <= byte_sum_d;
			record_type_q <= record_type_d;
			finished_q    <= finished_d;
			out_valid_q   <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_kind_q <= emit_kind;
			out_byte_q <= emit_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;

`ifndef SYNTHESIS
	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("end-of-file flag cleared without reset");

	a_eof_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == hexrp_pkg::KIND_EOF) |-> finished_q)
		else $error("end-of-file word without end-of-file state");

	a_status_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != hexrp_pkg::KIND_DATA) |-> (m_tdata == 8'd0))
		else $error("status word carries a nonzero byte");

	a_data_type_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == hexrp_pkg::KIND_DATA) |->
		(record_type_q == hexrp_pkg::TYPE_DATA && in_record_q))
		else $error("data word outside a data record");
`endif

endmodule
